/* design/pptu_pkg.sv */
// Shared types, constants and helpers for the pointer position tracker.
// No dependencies; every other design file imports this package.
`default_nettype none

package pptu_pkg;

    // Cursor register width; outputs are sign-extended from it to 32 bits.
    localparam int POS_W = 32;
    // Relative update sum: 32-bit cursor plus a 34-bit scaled delta.
    localparam int SUM_W = 35;
    // Absolute scaling dividend: 32-bit offset times 16-bit viewport.
    localparam int DVD_W = 48;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int CFG_ADDR_W = 5;

    localparam logic signed [SUM_W-1:0] POS_HI =
        SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

    localparam logic [15:0] EV_RELATIVE = 16'd2;
    localparam logic [15:0] EV_ABSOLUTE = 16'd3;
    localparam logic [15:0] AXIS_X      = 16'd0;
    localparam logic [15:0] AXIS_Y      = 16'd1;

    localparam logic [2:0] REG_VIEW_W = 3'd0;
    localparam logic [2:0] REG_VIEW_H = 3'd1;
    localparam logic [2:0] REG_X_MIN  = 3'd2;
    localparam logic [2:0] REG_X_MAX  = 3'd3;
    localparam logic [2:0] REG_Y_MIN  = 3'd4;
    localparam logic [2:0] REG_Y_MAX  = 3'd5;

    localparam logic [15:0] VIEW_W_RESET = 16'd640;
    localparam logic [15:0] VIEW_H_RESET = 16'd480;

    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } evt_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } pos_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_REL_X,
        OP_REL_Y,
        OP_ABS_X,
        OP_ABS_Y
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
        logic signed [32:0] numer;  // raw value minus axis minimum
        logic [31:0]        range;  // axis span, already forced to at least 1
        logic [15:0]        view;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = v;
        if (v > POS_HI)
        begin
            r = POS_HI;
        end
        else if (v < POS_LO)
        begin
            r = POS_LO;
        end
        return r[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/pptu_front.sv */
// Front end: configuration registers, event classification and axis offsets.
// Depends on pptu_pkg; feeds pptu_cmd_queue.
`default_nettype none

module pptu_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pptu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    input  wire logic                           push,
    input  wire pptu_pkg::evt_t                 evt,
    input  wire logic                           q_full,
    output logic                                q_wr,
    output pptu_pkg::cmd_t                      q_cmd
);
    import pptu_pkg::*;

    logic [15:0]        view_w_reg;
    logic [15:0]        view_h_reg;
    logic signed [31:0] x_min_reg;
    logic signed [31:0] x_max_reg;
    logic signed [31:0] y_min_reg;
    logic signed [31:0] y_max_reg;

    logic               cfg_wr;
    logic [2:0]         reg_idx;
    op_t                op;
    logic               use_y;
    logic signed [31:0] sel_min;
    logic signed [31:0] sel_max;
    logic signed [32:0] span;

    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_w_reg <= VIEW_W_RESET;
            view_h_reg <= VIEW_H_RESET;
            x_min_reg  <= '0;
            x_max_reg  <= '0;
            y_min_reg  <= '0;
            y_max_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_VIEW_W: view_w_reg <= pwdata[15:0];
                REG_VIEW_H: view_h_reg <= pwdata[15:0];
                REG_X_MIN:  x_min_reg  <= pwdata;
                REG_X_MAX:  x_max_reg  <= pwdata;
                REG_Y_MIN:  y_min_reg  <= pwdata;
                REG_Y_MAX:  y_max_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VIEW_W: prdata = {16'b0, view_w_reg};
            REG_VIEW_H: prdata = {16'b0, view_h_reg};
            REG_X_MIN:  prdata = x_min_reg;
            REG_X_MAX:  prdata = x_max_reg;
            REG_Y_MIN:  prdata = y_min_reg;
            REG_Y_MAX:  prdata = y_max_reg;
            default:    prdata = '0;
        endcase
    end

    // Classify the event into one back-end operation.
    always_comb
    begin
        op = OP_NOP;
        if (evt.event_type == EV_RELATIVE)
        begin
            if (evt.event_code == AXIS_X)
            begin
                op = OP_REL_X;
            end
            else if (evt.event_code == AXIS_Y)
            begin
                op = OP_REL_Y;
            end
        end
        else if (evt.event_type == EV_ABSOLUTE)
        begin
            if (evt.event_code == AXIS_X)
            begin
                op = OP_ABS_X;
            end
            else if (evt.event_code == AXIS_Y)
            begin
                op = OP_ABS_Y;
            end
        end
    end

    assign use_y   = (op == OP_ABS_Y);
    assign sel_min = use_y ? y_min_reg : x_min_reg;
    assign sel_max = use_y ? y_max_reg : x_max_reg;
    assign span    = 33'(sel_max) - 33'(sel_min);

    always_comb
    begin
        q_cmd.op    = op;
        q_cmd.value = evt.event_value;
        q_cmd.numer = 33'(evt.event_value) - 33'(sel_min);
        // Empty or inverted range divides by one.
        q_cmd.range = (span < 33'sd1) ? 32'd1 : span[31:0];
        q_cmd.view  = use_y ? view_h_reg : view_w_reg;
    end

    assign q_wr = push & ~q_full;

endmodule

`default_nettype wire

/* design/pptu_cmd_queue.sv */
// Two-entry command queue between the front end and the execution back end.
// Depends on pptu_pkg for the command type.
`default_nettype none

module pptu_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire pptu_pkg::cmd_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output pptu_pkg::cmd_t      rd_data,
    output logic                empty
);
    import pptu_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);

endmodule

`default_nettype wire

/* design/pptu_back.sv */
// Back end: cursor state, relative saturation, absolute scaling through a
// multiply and a bit-serial restoring divider, and the result register.
// Depends on pptu_pkg; reads commands from pptu_cmd_queue.
`default_nettype none

module pptu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire pptu_pkg::cmd_t q_cmd,
    output logic                q_rd,
    output pptu_pkg::pos_t      pos,
    output logic                empty,
    input  wire logic           pop
);
    import pptu_pkg::*;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic signed [POS_W-1:0] cursor_x_reg, cursor_x_next;
    logic signed [POS_W-1:0] cursor_y_reg, cursor_y_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [31:0]            rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    pos_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [SUM_W-1:0] scaled;
    logic [DVD_W-1:0]        product;
    logic [32:0]             trial;
    logic [32:0]             diff;
    logic                    ge;
    logic [15:0]             view_m1;
    logic [15:0]             clamped;
    logic signed [POS_W-1:0] abs_pos;

    assign scaled  = SUM_W'(cmd_reg.value) <<< 2;
    assign product = DVD_W'(cmd_reg.numer[31:0]) * DVD_W'(cmd_reg.view);
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = trial - {1'b0, cmd_reg.range};
    assign ge      = ~diff[32];
    assign view_m1 = cmd_reg.view - 16'd1;
    assign clamped = (dvd_reg > DVD_W'(view_m1)) ? view_m1 : dvd_reg[15:0];
    assign abs_pos = sat_pos(SUM_W'({1'b0, clamped}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~pop;
        q_rd           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg.op)
                    OP_REL_X: cursor_x_next = sat_pos(SUM_W'(cursor_x_reg) + scaled);
                    OP_REL_Y: cursor_y_next = sat_pos(SUM_W'(cursor_y_reg) - scaled);
                    OP_ABS_X, OP_ABS_Y:
                    begin
                        // Zero viewport or a value below the axis minimum lands at 0.
                        if ((cmd_reg.view == 16'd0) || cmd_reg.numer[32])
                        begin
                            if (cmd_reg.op == OP_ABS_X)
                            begin
                                cursor_x_next = '0;
                            end
                            else
                            begin
                                cursor_y_next = '0;
                            end
                        end
                        else
                        begin
                            dvd_next   = product;
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                // One quotient bit per cycle; quotient shifts in behind the dividend.
                rem_next = ge ? diff[31:0] : trial[31:0];
                dvd_next = {dvd_reg[DVD_W-2:0], ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (cmd_reg.op == OP_ABS_X)
                begin
                    cursor_x_next = abs_pos;
                end
                else
                begin
                    cursor_y_next = abs_pos;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the result register frees up.
                if (!out_valid_reg || pop)
                begin
                    out_next.pos_x = 32'(cursor_x_reg);
                    out_next.pos_y = 32'(cursor_y_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pos   = out_reg;
    assign empty = ~out_valid_reg;

endmodule

`default_nettype wire

/* design/pointer_position_tracker_unit.sv */
// Pointer position tracker: top level joining front end, command queue and back end.
// Depends on pptu_pkg, pptu_front, pptu_cmd_queue and pptu_back.
//
// Usage:
//   Input channel: present an event on evt and raise push; the transaction is
//   taken on a clock edge where push is high and full is low. Result channel:
//   while empty is low, pos holds the oldest result; raise pop to take it.
//   Every event yields exactly one result with the position after that event.
//   Configuration: APB-style registers at byte addresses 0x00..0x14 (viewport
//   width and height, X min/max, Y min/max); write only while the block is idle.
// Timing:
//   Relative, unknown and degenerate absolute events pass from the queue through
//   the IDLE, EXEC and DONE states to the result. Absolute events also run a 48-step
//   restoring divider, one quotient bit per cycle; that divider sets throughput.
//   The back end works on one event at a time; a two-entry command queue keeps
//   accepting while it is busy, so full rises once two events are waiting.
// Reset: cursor goes to (0, 0), viewport to 640 x 480, axis limits to 0.
// Stall: while a result is not popped, the back end holds its next result and
//   the command queue fills; nothing is dropped.
`default_nettype none

module pointer_position_tracker_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pptu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           push,
    output logic                                full,
    input  wire pptu_pkg::evt_t                 evt,
    output logic                                empty,
    input  wire logic                           pop,
    output pptu_pkg::pos_t                      pos
);
    import pptu_pkg::*;

    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;
    cmd_t q_wr_cmd;
    cmd_t q_rd_cmd;

    assign pready = 1'b1;
    assign full   = q_full;

    pptu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .push    (push),
        .evt     (evt),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_cmd   (q_wr_cmd)
    );

    pptu_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_cmd),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_cmd),
        .empty   (q_empty)
    );

    pptu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_rd_cmd),
        .q_rd    (q_rd),
        .pos     (pos),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
